FILE: rtl/ljpe_pkg.sv
// Shared types and constants for the Lennard-Jones pair energy pipeline.
// No dependencies; imported by the axis lane and the top level.
package ljpe_pkg;

  localparam int COORD_W  = 32;  // signed Q16.16 coordinate
  localparam int DIFF_W   = 33;  // coordinate difference
  localparam int BOX_W    = 31;  // box length
  localparam int SQ_W     = 64;  // squared axis distance
  localparam int R2_W     = 66;  // sum of up to three squares
  localparam int LQ_W     = 34;  // image index quotient bits
  localparam int LANE_LAT = 38;  // input stage + divider + product + fold + square
  localparam int EQ_W     = 41;  // sigma^2 / r^2 quotient bits
  localparam int S_W      = 40;  // ratio s kept below 2^40

  typedef enum logic [2:0] {
    REG_DIMENSIONS,
    REG_PERIODIC,
    REG_BOX_X,
    REG_BOX_Y,
    REG_BOX_Z,
    REG_WELL_DEPTH,
    REG_CORE_RADIUS,
    REG_ENERGY_SHIFT
  } cfg_reg_t;

  typedef struct packed {
    logic fold;  // apply nearest image folding on this axis
    logic used;  // axis counts toward r^2
  } lane_ctl_t;

endpackage

FILE: rtl/ljpe_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; used by the axis lanes and the energy path of the top level.
module ljpe_div #(
  parameter int QW = 34,
  parameter int DW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic [DW-1:0] rem_in,
  input  logic [QW-1:0] bits_in,
  input  logic [DW-1:0] den_in,
  input  logic [SW-1:0] side_in,
  output logic [QW-1:0] quot,
  output logic [SW-1:0] side_out
);

  logic [DW-1:0] rem_s  [0:QW];
  logic [QW-1:0] bits_s [0:QW];
  logic [DW-1:0] den_s  [0:QW];
  logic [QW-1:0] q_s    [0:QW];
  logic [SW-1:0] side_s [0:QW];

  assign rem_s[0]  = rem_in;
  assign bits_s[0] = bits_in;
  assign den_s[0]  = den_in;
  assign q_s[0]    = '0;
  assign side_s[0] = side_in;

  for (genvar t = 0; t < QW; t++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diffv;
    logic        ge;

    // shift in the next numerator bit, subtract when it fits
    assign trial = {rem_s[t], bits_s[t][QW-1-t]};
    assign diffv = trial - {1'b0, den_s[t]};
    assign ge    = trial >= {1'b0, den_s[t]};

    always_ff @(posedge clk) begin
      rem_s[t+1]  <= ge ? diffv[DW-1:0] : trial[DW-1:0];
      bits_s[t+1] <= bits_s[t];
      den_s[t+1]  <= den_s[t];
      q_s[t+1]    <= {q_s[t][QW-2:0], ge};
      side_s[t+1] <= side_s[t];
    end
  end

  assign quot     = q_s[QW];
  assign side_out = side_s[QW];

endmodule

FILE: rtl/ljpe_mul.sv
// Two-stage unsigned multiplier built from 32x32 partial products.
// Standalone; used by the energy path of the top level.
module ljpe_mul #(
  parameter int WA = 40,
  parameter int WB = 40
) (
  input  logic             clk,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] prod
);

  localparam int NA   = (WA + 31) / 32;
  localparam int NB   = (WB + 31) / 32;
  localparam int SUMW = (NA + NB) * 32;

  logic [NA*32-1:0] a_pad;
  logic [NB*32-1:0] b_pad;
  logic [63:0]      pp [NA][NB];
  logic [SUMW-1:0]  acc;

  assign a_pad = (NA*32)'(a);
  assign b_pad = (NB*32)'(b);

  always_ff @(posedge clk) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp[i][j] <= a_pad[32*i +: 32] * b_pad[32*j +: 32];
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (SUMW'(pp[i][j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= acc[WA+WB-1:0];
  end

endmodule

FILE: rtl/ljpe_lane.sv
// One axis lane: difference, nearest image folding and square.
// Depends on ljpe_pkg and ljpe_div.
module ljpe_lane
  import ljpe_pkg::*;
(
  input  logic                      clk,
  input  logic signed [COORD_W-1:0] first,
  input  logic signed [COORD_W-1:0] second,
  input  logic        [BOX_W-1:0]   box,
  input  lane_ctl_t                 ctl,
  output logic        [SQ_W-1:0]    sq
);

  localparam int SIDE_W = DIFF_W + 1 + $bits(lane_ctl_t);

  logic signed [DIFF_W-1:0] d_c;
  logic signed [DIFF_W+1:0] n_c;
  logic        [LQ_W-1:0]   a_c;
  logic        [LQ_W-1:0]   a0;
  logic        [SIDE_W-1:0] side0;
  logic        [LQ_W-1:0]   q;
  logic        [SIDE_W-1:0] side1;
  logic signed [DIFF_W-1:0] d1;
  logic                     neg1;
  lane_ctl_t                ctl1;
  logic signed [LQ_W:0]     k;
  logic signed [66:0]       prod;
  logic signed [DIFF_W-1:0] d2;
  lane_ctl_t                ctl2;
  logic signed [DIFF_W-1:0] df;
  logic        [31:0]       mag;
  logic                     used3;

  // k = floor((2d + L) / 2L); for negative n use floor(n/m) = ~floor(~n/m)
  assign d_c = {first[COORD_W-1], first} - {second[COORD_W-1], second};
  assign n_c = {d_c[DIFF_W-1], d_c, 1'b0} + {4'b0, box};
  assign a_c = n_c[DIFF_W+1] ? ~n_c[LQ_W-1:0] : n_c[LQ_W-1:0];

  always_ff @(posedge clk) begin
    a0    <= a_c;
    side0 <= {d_c, n_c[DIFF_W+1], ctl};
  end

  ljpe_div #(
    .QW(LQ_W),
    .DW(BOX_W + 1),
    .SW(SIDE_W)
  ) u_div (
    .clk     (clk),
    .rem_in  ('0),
    .bits_in (a0),
    .den_in  ({box, 1'b0}),
    .side_in (side0),
    .quot    (q),
    .side_out(side1)
  );

  assign {d1, neg1, ctl1} = side1;
  assign k = neg1 ? ~{1'b0, q} : {1'b0, q};

  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, box}) * k;
    d2   <= d1;
    ctl2 <= ctl1;
  end

  assign df = ctl2.fold ? (d2 - prod[DIFF_W-1:0]) : d2;

  always_ff @(posedge clk) begin
    mag   <= df[DIFF_W-1] ? 32'(-df) : df[31:0];
    used3 <= ctl2.used;
  end

  always_ff @(posedge clk) begin
    sq <= used3 ? SQ_W'(mag) * SQ_W'(mag) : '0;
  end

endmodule

FILE: rtl/lennard_jones_pair_energy.sv
// Channel   | Ports                                         | Handshake
// ----------+-----------------------------------------------+---------------------------
// input     | first_x/y/z, second_x/y/z                      | start && !busy
// result    | pair_energy, saturated                         | done, one cycle, no stall
// config    | cfg_index, cfg_data                            | cfg_we
//
// One transaction per clock while busy is low.
// Latency is set by the two restoring divider pipelines (image index per axis,
// sigma^2 / r^2) and the chain of two-stage multipliers for s^2, s^3, s^6.
// rst is synchronous: it clears the valid line and sets busy until rst is released.
// The result side cannot stall, so nothing ever holds the pipeline.
// Top level of the Lennard-Jones pair energy block.
// Depends on ljpe_pkg, ljpe_lane, ljpe_div and ljpe_mul.
module lennard_jones_pair_energy
  import ljpe_pkg::*;
#(
  parameter int MAX_DIM = 3
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] first_x,
  input  logic signed [COORD_W-1:0] first_y,
  input  logic signed [COORD_W-1:0] first_z,
  input  logic signed [COORD_W-1:0] second_x,
  input  logic signed [COORD_W-1:0] second_y,
  input  logic signed [COORD_W-1:0] second_z,
  output logic                      done,
  output logic signed [63:0]        pair_energy,
  output logic                      saturated,
  input  logic                      cfg_we,
  input  logic        [2:0]         cfg_index,
  input  logic        [63:0]        cfg_data
);

  localparam int TOTAL = LANE_LAT + 2 + EQ_W + 11;
  localparam int FLAG_DLY = 10;

  logic [1:0]         dimensions;
  logic               periodic;
  logic [BOX_W-1:0]   box [3];
  logic [31:0]        well_depth;
  logic [31:0]        core_radius;
  logic [63:0]        energy_shift;
  logic [63:0]        sig2;

  logic               acc;
  logic [TOTAL-1:0]   vld;

  logic signed [COORD_W-1:0] fa [3];
  logic signed [COORD_W-1:0] sa [3];
  logic [SQ_W-1:0]    sq_l [MAX_DIM];
  logic [R2_W-1:0]    r2_sum;
  logic [R2_W-1:0]    r2_m;
  logic [R2_W-1:0]    r2_f;
  logic               zero_f;
  logic               ov_f;

  logic [EQ_W-1:0]    q_d;
  logic [1:0]         flg_d;
  logic [S_W-1:0]     s;
  logic [S_W-1:0]     s_dly [2];
  logic [2*S_W-1:0]   p1;
  logic [47:0]        s2;
  logic [87:0]        p2;
  logic [55:0]        s3;
  logic [55:0]        s3_dly [2];
  logic [111:0]       p3;
  logic [79:0]        s6;
  logic               neg_r;
  logic [79:0]        diff_r;
  logic               neg_dly [2];
  logic [111:0]       p4;
  logic [112:0]       t_c;
  logic signed [98:0] e_r;
  logic [1:0]         flg_pipe [FLAG_DLY];
  logic signed [99:0] e_use;
  logic signed [99:0] res;
  logic               fits;

  assign acc = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dimensions   <= 2'd3;
      periodic     <= 1'b1;
      box[0]       <= BOX_W'(655360);
      box[1]       <= BOX_W'(655360);
      box[2]       <= BOX_W'(655360);
      well_depth   <= 32'd65536;
      core_radius  <= 32'd65536;
      energy_shift <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DIMENSIONS:   dimensions   <= cfg_data[1:0];
        REG_PERIODIC:     periodic     <= cfg_data[0];
        REG_BOX_X:        box[0]       <= cfg_data[BOX_W-1:0];
        REG_BOX_Y:        box[1]       <= cfg_data[BOX_W-1:0];
        REG_BOX_Z:        box[2]       <= cfg_data[BOX_W-1:0];
        REG_WELL_DEPTH:   well_depth   <= cfg_data[31:0];
        REG_CORE_RADIUS:  core_radius  <= cfg_data[31:0];
        REG_ENERGY_SHIFT: energy_shift <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sig2 <= core_radius * core_radius;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[TOTAL-2:0], acc};
    end
  end

  assign fa[0] = first_x;
  assign fa[1] = first_y;
  assign fa[2] = first_z;
  assign sa[0] = second_x;
  assign sa[1] = second_y;
  assign sa[2] = second_z;

  for (genvar i = 0; i < MAX_DIM; i++) begin : g_lane
    lane_ctl_t ctl;

    assign ctl.fold = periodic && (box[i] != '0);
    assign ctl.used = 2'(i) < dimensions;

    ljpe_lane u_lane (
      .clk   (clk),
      .first (fa[i]),
      .second(sa[i]),
      .box   (box[i]),
      .ctl   (ctl),
      .sq    (sq_l[i])
    );
  end

  // merge the lanes
  always_comb begin
    r2_sum = '0;
    for (int i = 0; i < MAX_DIM; i++) begin
      r2_sum = r2_sum + R2_W'(sq_l[i]);
    end
  end

  // s >= 2^40 exactly when sigma^2 >= r^2 * 256
  always_ff @(posedge clk) begin
    r2_m   <= r2_sum;
    r2_f   <= r2_m;
    zero_f <= r2_m == '0;
    ov_f   <= {10'b0, sig2} >= {r2_m, 8'b0};
  end

  ljpe_div #(
    .QW(EQ_W),
    .DW(R2_W),
    .SW(2)
  ) u_ediv (
    .clk     (clk),
    .rem_in  (R2_W'(sig2[63:9])),
    .bits_in ({sig2[8:0], 32'b0}),
    .den_in  (r2_f),
    .side_in ({zero_f, ov_f}),
    .quot    (q_d),
    .side_out(flg_d)
  );

  assign s = q_d[S_W-1:0];

  ljpe_mul #(.WA(S_W), .WB(S_W)) u_mul_s2 (.clk(clk), .a(s), .b(s), .prod(p1));

  always_ff @(posedge clk) begin
    s_dly[0] <= s;
    s_dly[1] <= s_dly[0];
  end

  assign s2 = p1[79:32];

  ljpe_mul #(.WA(48), .WB(S_W)) u_mul_s3 (.clk(clk), .a(s2), .b(s_dly[1]), .prod(p2));

  assign s3 = p2[87:32];

  ljpe_mul #(.WA(56), .WB(56)) u_mul_s6 (.clk(clk), .a(s3), .b(s3), .prod(p3));

  always_ff @(posedge clk) begin
    s3_dly[0] <= s3;
    s3_dly[1] <= s3_dly[0];
  end

  assign s6 = p3[111:32];

  always_ff @(posedge clk) begin
    neg_r  <= s6 < {24'b0, s3_dly[1]};
    diff_r <= (s6 < {24'b0, s3_dly[1]}) ? ({24'b0, s3_dly[1]} - s6)
                                         : (s6 - {24'b0, s3_dly[1]});
  end

  ljpe_mul #(.WA(32), .WB(80)) u_mul_e (.clk(clk), .a(well_depth), .b(diff_r), .prod(p4));

  always_ff @(posedge clk) begin
    neg_dly[0] <= neg_r;
    neg_dly[1] <= neg_dly[0];
  end

  // floor division by 2^14 of the signed product
  assign t_c = neg_dly[1] ? -{1'b0, p4} : {1'b0, p4};

  always_ff @(posedge clk) begin
    e_r <= t_c[112:14];
  end

  always_ff @(posedge clk) begin
    flg_pipe[0] <= flg_d;
    for (int i = 1; i < FLAG_DLY; i++) begin
      flg_pipe[i] <= flg_pipe[i-1];
    end
  end

  assign e_use = (well_depth != '0) ? {e_r[98], e_r} : '0;
  assign res   = e_use - {{36{energy_shift[63]}}, energy_shift};
  assign fits  = (&res[99:63]) || !(|res[99:63]);

  always_ff @(posedge clk) begin
    if (flg_pipe[FLAG_DLY-1][1] || (flg_pipe[FLAG_DLY-1][0] && well_depth != '0)) begin
      pair_energy <= {1'b0, {63{1'b1}}};
      saturated   <= 1'b1;
    end else if (fits) begin
      pair_energy <= res[63:0];
      saturated   <= 1'b0;
    end else if (res[99]) begin
      pair_energy <= {1'b1, 63'b0};
      saturated   <= 1'b1;
    end else begin
      pair_energy <= {1'b0, {63{1'b1}}};
      saturated   <= 1'b1;
    end
  end

  assign done = vld[TOTAL-1];

`ifndef SYNTHESIS
  a_done_follows_start : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(acc, TOTAL))
    else $error("result strobe without a matching start");

  a_reset_quiet : assert property (@(posedge clk)
    rst |=> (!done && busy))
    else $error("strobe or accept right after reset");

  a_zero_saturates : assert property (@(posedge clk) disable iff (rst)
    (vld[TOTAL-2] && flg_pipe[FLAG_DLY-1][1]) |=> (done && saturated))
    else $error("zero distance did not saturate");
`endif

endmodule

FILE: tb/lennard_jones_pair_energy_tb.sv
// Testbench for lennard_jones_pair_energy: directed and random particle pairs
// over several register settings, checked against a scoreboard predictor.
// Depends on ljpe_pkg and the lennard_jones_pair_energy RTL.
module lennard_jones_pair_energy_tb;
  import ljpe_pkg::*;

  typedef struct {
    logic signed [31:0] ax, ay, az, bx, by, bz;
  } pair_t;

  typedef struct {
    logic [63:0] energy;
    logic        sat;
  } energy_t;

  class energy_scoreboard;
    logic [1:0]  dims;
    logic        periodic;
    logic [30:0] box [3];
    logic [31:0] eps, sigma;
    logic [63:0] shift;
    energy_t     pending [$];
    int          mismatches;
    int          checked;

    function energy_t predict(pair_t p);
      logic signed [31:0] a [3];
      logic signed [31:0] b [3];
      longint      d, num, den, k, len;
      logic [63:0] mag, sig2, s, s2, s3;
      logic [127:0] r2, q, s6, prod, e, res;
      energy_t     r;
      a[0] = p.ax; a[1] = p.ay; a[2] = p.az;
      b[0] = p.bx; b[1] = p.by; b[2] = p.bz;
      r2 = '0;
      for (int i = 0; i < dims; i++) begin
        d = longint'(a[i]) - longint'(b[i]);
        len = longint'({1'b0, box[i]});
        if (periodic && len != 0) begin
          num = 2 * d + len;
          den = 2 * len;
          k = num / den;
          if (num % den != 0 && num < 0) k--;
          d = d - len * k;
        end
        mag = d < 0 ? -d : d;
        r2 = r2 + {64'd0, mag * mag};
      end
      if (r2 == 0) begin
        r.energy = 64'h7FFF_FFFF_FFFF_FFFF;
        r.sat = 1'b1;
        return r;
      end
      e = '0;
      if (eps != 0) begin
        sig2 = {32'd0, sigma} * {32'd0, sigma};
        q = {32'd0, sig2, 32'd0} / r2;
        if (q >= (128'd1 << 40)) begin
          r.energy = 64'h7FFF_FFFF_FFFF_FFFF;
          r.sat = 1'b1;
          return r;
        end
        s = q[63:0];
        prod = {64'd0, s} * {64'd0, s};
        s2 = prod[95:32];
        prod = {64'd0, s2} * {64'd0, s};
        s3 = prod[95:32];
        prod = {64'd0, s3} * {64'd0, s3};
        s6 = prod >> 32;
        if (s6 >= {64'd0, s3}) begin
          prod = {96'd0, eps} * (s6 - {64'd0, s3});
          e = prod >> 14;
        end else begin
          prod = {96'd0, eps} * ({64'd0, s3} - s6);
          e = -((prod + 128'd16383) >> 14);
        end
      end
      res = e - {{64{shift[63]}}, shift};
      r.sat = 1'b0;
      if (res[127:63] == '0 || res[127:63] == '1) r.energy = res[63:0];
      else begin
        r.sat = 1'b1;
        r.energy = res[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
      return r;
    endfunction

    function void note_pair(pair_t p);
      pending.push_back(predict(p));
    endfunction

    function void check_energy(logic [63:0] energy, logic sat);
      energy_t x;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result energy=%h sat=%b", energy, sat);
        return;
      end
      x = pending.pop_front();
      if (x.energy !== energy || x.sat !== sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected energy=%h sat=%b, got energy=%h sat=%b",
                   x.energy, x.sat, energy, sat);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] first_x = '0, first_y = '0, first_z = '0;
  logic signed [31:0] second_x = '0, second_y = '0, second_z = '0;
  logic               done;
  logic signed [63:0] pair_energy;
  logic               saturated;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;

  energy_scoreboard   board;
  int                 cycles;
  int                 sent;
  localparam int      CYCLE_LIMIT = 2000000;

  lennard_jones_pair_energy dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) board.check_energy(pair_energy, saturated);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL lennard_jones_pair_energy");
      $finish;
    end
  end

  task automatic write_all(logic [1:0] dm, logic pr, logic [30:0] bxl, logic [30:0] byl,
                           logic [30:0] bzl, logic [31:0] ep, logic [31:0] sg,
                           logic [63:0] sh);
    logic [63:0] vals [8];
    vals[0] = dm; vals[1] = pr; vals[2] = bxl; vals[3] = byl; vals[4] = bzl;
    vals[5] = ep; vals[6] = sg; vals[7] = sh;
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    board.dims = dm; board.periodic = pr;
    board.box[0] = bxl; board.box[1] = byl; board.box[2] = bzl;
    board.eps = ep; board.sigma = sg; board.shift = sh;
    @(posedge clk);
  endtask

  // hold the pair until the block takes it, then optionally go idle
  task automatic send_pair(pair_t p, int idle_pct);
    start    <= 1'b1;
    first_x  <= p.ax; first_y  <= p.ay; first_z  <= p.az;
    second_x <= p.bx; second_y <= p.by; second_z <= p.bz;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_pair(p);
    sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic pair_t random_pair();
    pair_t p;
    int    spread;
    p.ax = $urandom; p.ay = $urandom; p.az = $urandom;
    if ($urandom_range(9) < 2) begin
      p.bx = $urandom; p.by = $urandom; p.bz = $urandom;
    end else begin
      // keep the partner near so the energy lands in the interesting range
      spread = $urandom_range(3) == 0 ? 32'h0002_0000 : 32'h0004_0000;
      p.bx = p.ax + $signed($urandom_range(2 * spread) - spread);
      p.by = p.ay + $signed($urandom_range(2 * spread) - spread);
      p.bz = p.az + $signed($urandom_range(2 * spread) - spread);
    end
    return p;
  endfunction

  task automatic random_phase(int n, int idle_pct);
    for (int i = 0; i < n; i++) send_pair(random_pair(), idle_pct);
    drain();
  endtask

  function automatic pair_t mk(int ax, int ay, int az, int bx, int by, int bz);
    pair_t p;
    p.ax = ax; p.ay = ay; p.az = az; p.bx = bx; p.by = by; p.bz = bz;
    return p;
  endfunction

  initial begin
    board = new();
    cycles = 0;
    sent = 0;
    board.dims = 3; board.periodic = 1'b1;
    board.box[0] = 655360; board.box[1] = 655360; board.box[2] = 655360;
    board.eps = 65536; board.sigma = 65536; board.shift = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed pairs under reset settings
    send_pair(mk(0, 0, 0, 0, 0, 0), 0);                          // zero distance
    send_pair(mk(65536, 0, 0, 0, 0, 0), 0);                      // r equals sigma
    send_pair(mk(100, 0, 0, 0, 0, 0), 0);                        // huge ratio
    send_pair(mk(72000, 0, 0, 0, 0, 0), 0);                      // near the well
    send_pair(mk(327680, 0, 0, 0, 0, 0), 0);                     // exactly half a box
    send_pair(mk(-327680, 0, 0, 0, 0, 0), 0);                    // minus half a box
    send_pair(mk(655360, 0, 0, 0, 0, 0), 0);                     // folds to zero
    send_pair(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000), 0);
    send_pair(mk(-1, -1, -1, 0, 0, 0), 0);
    send_pair(mk(131072, 65536, -65536, 0, 0, 0), 0);
    drain();

    // open and periodic boundaries, one to three axes, extreme shift, extreme coordinates
    write_all(2'd1, 1'b0, 31'd1, 31'h7FFF_FFFF, 31'd1, 32'hFFFF_FFFF, 32'd1,
              64'h8000_0000_0000_0000);
    send_pair(mk(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0), 0);
    send_pair(mk(1, 5, 5, 0, 0, 0), 0);
    send_pair(mk(0, 5, 9, 0, 0, 0), 0);
    drain();
    write_all(2'd2, 1'b1, 31'd1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF,
              64'h7FFF_FFFF_FFFF_FFFF);
    send_pair(mk(3, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0), 0);
    send_pair(mk(0, 1, 0, 0, 0, 0), 0);
    drain();
    write_all(2'd3, 1'b0, 31'd65536, 31'd65536, 31'd65536, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 64'd0);
    send_pair(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0);
    send_pair(mk(65536, 0, 0, 0, 0, 0), 0);
    drain();

    // random phases with varied settings and sender gaps
    write_all(2'd3, 1'b1, 31'd655360, 31'd655360, 31'd655360, 32'd65536, 32'd65536,
              64'd0);
    random_phase(150, 0);
    write_all(2'd3, 1'b1, 31'd200000, 31'd300000, 31'd400000, 32'd98304, 32'd70000,
              64'hFFFF_FFFF_8000_0000);
    random_phase(150, 53);
    write_all(2'd2, 1'b0, 31'h7FFF_FFFF, 31'd1, 31'd1, $urandom, 32'd90000,
              {$urandom, $urandom});
    random_phase(120, 7);
    write_all(2'd1, 1'b1, 31'd150000, 31'd1, 31'd1, 32'd65536, 32'd65536, 64'd12345);
    random_phase(120, 53);
    write_all(2'd3, 1'b0, 31'd1, 31'd1, 31'd1, 32'hFFFF_FFFF, 32'd80000, 64'd0);
    random_phase(150, 0);

    $display("covered %0d pairs, %0d results, over eight register settings",
             sent, board.checked);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("PASS lennard_jones_pair_energy");
    else begin
      $display("%0d mismatches, %0d results missing", board.mismatches,
               board.pending.size());
      $display("FAIL lennard_jones_pair_energy");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ljpe_pkg.sv
rtl/ljpe_div.sv
rtl/ljpe_mul.sv
rtl/ljpe_lane.sv
rtl/lennard_jones_pair_energy.sv
tb/lennard_jones_pair_energy_tb.sv
